/* rtl/vlm_pkg.sv */
// ----------------------------------------------------------------------------
// vlm_pkg
// Shared widths, codes and types of the velocity limit monitor.
// ----------------------------------------------------------------------------
package vlm_pkg;

  // velocity sample width (signed Q4.12 at 16 bits)
  localparam int VEL_WIDTH = 16;

  // derived widths
  localparam int VEL_SQ_W  = 2 * VEL_WIDTH;
  localparam int SUM_W     = VEL_SQ_W + 2;
  localparam int LIM_W     = 15;
  localparam int LIM_SQ_W  = 2 * LIM_W;
  localparam int CMP_W     = (SUM_W > LIM_SQ_W) ? SUM_W : LIM_SQ_W;
  localparam int AXIS_W    = (VEL_WIDTH > LIM_W) ? VEL_WIDTH : LIM_W;
  localparam int MODE_W    = 2;
  localparam int LEVEL_W   = 2;
  localparam int CODE_W    = 2;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MONITOR_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIN_SPEED  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LIMIT_Z   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ANG_SPEED_LIM  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE      = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY_LEVEL   = CFG_IDX_W'(7);

  // limit modes
  localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_AXIS = MODE_W'(1);

  // safety levels
  localparam logic [LEVEL_W-1:0] LEVEL_LOW    = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = LEVEL_W'(1);

  // commands
  localparam logic CMD_CHECK      = 1'b0;
  localparam logic CMD_RESET_STOP = 1'b1;

  // violation codes
  localparam logic [CODE_W-1:0] VIOL_SAFE    = CODE_W'(0);
  localparam logic [CODE_W-1:0] VIOL_LINEAR  = CODE_W'(1);
  localparam logic [CODE_W-1:0] VIOL_AXIS    = CODE_W'(2);
  localparam logic [CODE_W-1:0] VIOL_ANGULAR = CODE_W'(3);

  // reset values of the limits
  localparam logic [LIM_W-1:0] MAX_LIN_RST   = LIM_W'(4096);
  localparam logic [LIM_W-1:0] AXIS_LIM_RST  = LIM_W'(32767);
  localparam logic [LIM_W-1:0] ANG_LIM_RST   = LIM_W'(32767);
  localparam logic [LIM_SQ_W-1:0] MAX_LIN_SQ_RST =
    LIM_SQ_W'(MAX_LIN_RST) * LIM_SQ_W'(MAX_LIN_RST);
  localparam logic [LIM_SQ_W-1:0] ANG_SQ_RST =
    LIM_SQ_W'(ANG_LIM_RST) * LIM_SQ_W'(ANG_LIM_RST);

  // configuration as seen by the datapath (speed limits kept squared)
  typedef struct packed {
    logic                monitor_enable;
    logic [LIM_SQ_W-1:0] max_lin_sq;
    logic [LIM_W-1:0]    axis_limit_x;
    logic [LIM_W-1:0]    axis_limit_y;
    logic [LIM_W-1:0]    axis_limit_z;
    logic [LIM_SQ_W-1:0] ang_sq;
    logic [MODE_W-1:0]   axis_limit_mode;
    logic [LEVEL_W-1:0]  safety_level;
  } cfg_t;

  // beat between the square stage and the decision stage
  typedef struct packed {
    logic                valid;
    logic                command;
    logic [VEL_SQ_W-1:0] lin_sq_x;
    logic [VEL_SQ_W-1:0] lin_sq_y;
    logic [VEL_SQ_W-1:0] lin_sq_z;
    logic [VEL_SQ_W-1:0] ang_sq_x;
    logic [VEL_SQ_W-1:0] ang_sq_y;
    logic [VEL_SQ_W-1:0] ang_sq_z;
    logic                axis_over;
  } sq_beat_t;

endpackage

/* rtl/vlm_ifs.sv */
// ----------------------------------------------------------------------------
// vlm channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface vlm_in_if;
  import vlm_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [VEL_WIDTH-1:0] lin_x;
  logic signed [VEL_WIDTH-1:0] lin_y;
  logic signed [VEL_WIDTH-1:0] lin_z;
  logic signed [VEL_WIDTH-1:0] ang_x;
  logic signed [VEL_WIDTH-1:0] ang_y;
  logic signed [VEL_WIDTH-1:0] ang_z;

  modport source (output valid, command, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                  input ready);
  modport sink (input valid, command, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
                output ready);
endinterface

interface vlm_out_if;
  import vlm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] violation;
  logic              stop_active;
  logic              stop_raised;

  modport source (output valid, violation, stop_active, stop_raised, input ready);
  modport sink (input valid, violation, stop_active, stop_raised, output ready);
endinterface

interface vlm_cfg_if;
  import vlm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/velocity_limit_monitor.sv */
// ----------------------------------------------------------------------------
// velocity_limit_monitor
// Checks velocity samples against speed and per-axis limits, keeps a
// latched emergency stop.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    command, lin_x/y/z, ang_x/y/z
//  out_ch    out  valid/ready    violation, stop_active, stop_raised
//  cfg_ch    in   valid/ready    index, data (ready always high)
//
//  One beat per cycle while the output is not stalled; a result passes the
//  input register and then the result register before it is valid.
//  Six parallel squarers, the three-term sums and the compares sit between
//  the two registers.
//  Synchronous active-low reset clears the stop latch, the stage valids and
//  loads the register reset values.
//  A stalled output holds its result and backs pressure up to the input.
// ----------------------------------------------------------------------------
module velocity_limit_monitor (
  input logic       clk,
  input logic       rst_n,
  vlm_in_if.sink    in_ch,
  vlm_out_if.source out_ch,
  vlm_cfg_if.sink   cfg_ch
);
  import vlm_pkg::*;

  cfg_t     cfg;
  sq_beat_t sq_beat;
  logic     sq_ready;

  // register file
  vlm_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // input register and square logic
  vlm_square_stage u_square_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .sq_beat  (sq_beat),
    .sq_ready (sq_ready)
  );

  // decision and result stage
  vlm_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .sq_beat  (sq_beat),
    .sq_ready (sq_ready),
    .out_ch   (out_ch)
  );

endmodule

/* rtl/vlm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// vlm_cfg_regs
// Register file; speed limits are squared when written.
// ----------------------------------------------------------------------------
module vlm_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  vlm_cfg_if.sink       cfg_ch,
  output vlm_pkg::cfg_t cfg
);
  import vlm_pkg::*;

  cfg_t              cfg_r;
  logic [LIM_W-1:0]  wr_lim;
  logic [LIM_SQ_W-1:0] wr_lim_sq;

  // writes always taken
  assign cfg_ch.ready = 1'b1;

  // square of the written limit
  assign wr_lim    = cfg_ch.data[LIM_W-1:0];
  assign wr_lim_sq = LIM_SQ_W'(wr_lim) * LIM_SQ_W'(wr_lim);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.monitor_enable  <= 1'b1;
      cfg_r.max_lin_sq      <= MAX_LIN_SQ_RST;
      cfg_r.axis_limit_x    <= AXIS_LIM_RST;
      cfg_r.axis_limit_y    <= AXIS_LIM_RST;
      cfg_r.axis_limit_z    <= AXIS_LIM_RST;
      cfg_r.ang_sq          <= ANG_SQ_RST;
      cfg_r.axis_limit_mode <= MODE_NONE;
      cfg_r.safety_level    <= LEVEL_MEDIUM;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MONITOR_ENABLE: cfg_r.monitor_enable  <= cfg_ch.data[0];
        REG_MAX_LIN_SPEED:  cfg_r.max_lin_sq      <= wr_lim_sq;
        REG_AXIS_LIMIT_X:   cfg_r.axis_limit_x    <= wr_lim;
        REG_AXIS_LIMIT_Y:   cfg_r.axis_limit_y    <= wr_lim;
        REG_AXIS_LIMIT_Z:   cfg_r.axis_limit_z    <= wr_lim;
        REG_ANG_SPEED_LIM:  cfg_r.ang_sq          <= wr_lim_sq;
        REG_AXIS_MODE:      cfg_r.axis_limit_mode <= cfg_ch.data[MODE_W-1:0];
        REG_SAFETY_LEVEL:   cfg_r.safety_level    <= cfg_ch.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/vlm_square_stage.sv */
// ----------------------------------------------------------------------------
// vlm_square_stage
// Input register, then magnitudes, squares and per-axis checks.
// ----------------------------------------------------------------------------
module vlm_square_stage (
  input  logic              clk,
  input  logic              rst_n,
  vlm_in_if.sink            in_ch,
  input  vlm_pkg::cfg_t     cfg,
  output vlm_pkg::sq_beat_t sq_beat,
  input  logic              sq_ready
);
  import vlm_pkg::*;

  function automatic logic [VEL_WIDTH-1:0] magnitude(input logic [VEL_WIDTH-1:0] v);
    logic [VEL_WIDTH-1:0] neg;
    neg = ~v + VEL_WIDTH'(1);
    return v[VEL_WIDTH-1] ? neg : v;
  endfunction

  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  logic [VEL_WIDTH-1:0] s1_lx_r, s1_ly_r, s1_lz_r;
  logic [VEL_WIDTH-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic                 in_ready;
  logic [VEL_WIDTH-1:0] mag_lx, mag_ly, mag_lz, mag_ax, mag_ay, mag_az;
  sq_beat_t             sq_calc;

  // stage handshake
  assign in_ready     = !s1_valid_r || sq_ready;
  assign in_ch.ready  = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_cmd_r <= in_ch.command;
      s1_lx_r  <= in_ch.lin_x;
      s1_ly_r  <= in_ch.lin_y;
      s1_lz_r  <= in_ch.lin_z;
      s1_ax_r  <= in_ch.ang_x;
      s1_ay_r  <= in_ch.ang_y;
      s1_az_r  <= in_ch.ang_z;
    end
  end

  // magnitudes
  assign mag_lx = magnitude(s1_lx_r);
  assign mag_ly = magnitude(s1_ly_r);
  assign mag_lz = magnitude(s1_lz_r);
  assign mag_ax = magnitude(s1_ax_r);
  assign mag_ay = magnitude(s1_ay_r);
  assign mag_az = magnitude(s1_az_r);

  // squares and per-axis checks
  always_comb begin
    sq_calc.valid     = s1_valid_r;
    sq_calc.command   = s1_cmd_r;
    sq_calc.lin_sq_x  = VEL_SQ_W'(mag_lx) * VEL_SQ_W'(mag_lx);
    sq_calc.lin_sq_y  = VEL_SQ_W'(mag_ly) * VEL_SQ_W'(mag_ly);
    sq_calc.lin_sq_z  = VEL_SQ_W'(mag_lz) * VEL_SQ_W'(mag_lz);
    sq_calc.ang_sq_x  = VEL_SQ_W'(mag_ax) * VEL_SQ_W'(mag_ax);
    sq_calc.ang_sq_y  = VEL_SQ_W'(mag_ay) * VEL_SQ_W'(mag_ay);
    sq_calc.ang_sq_z  = VEL_SQ_W'(mag_az) * VEL_SQ_W'(mag_az);
    sq_calc.axis_over = (AXIS_W'(mag_lx) > AXIS_W'(cfg.axis_limit_x)) ||
                        (AXIS_W'(mag_ly) > AXIS_W'(cfg.axis_limit_y)) ||
                        (AXIS_W'(mag_lz) > AXIS_W'(cfg.axis_limit_z));
  end

  assign sq_beat = sq_calc;

endmodule

/* rtl/vlm_decide.sv */
// ----------------------------------------------------------------------------
// vlm_decide
// Magnitude compares, violation code, stop latch and result register.
// ----------------------------------------------------------------------------
module vlm_decide (
  input  logic              clk,
  input  logic              rst_n,
  input  vlm_pkg::cfg_t     cfg,
  input  vlm_pkg::sq_beat_t sq_beat,
  output logic              sq_ready,
  vlm_out_if.source         out_ch
);
  import vlm_pkg::*;

  logic [CMP_W-1:0]  lin_sum;
  logic [CMP_W-1:0]  ang_sum;
  logic              lin_over;
  logic              ang_over;
  logic [CODE_W-1:0] code;
  logic              raised;
  logic              latch_nxt;
  logic              take;
  logic              stop_latch_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] viol_r;
  logic              active_r;
  logic              raised_r;

  // handshake
  assign sq_ready = !out_valid_r || out_ch.ready;
  assign take     = sq_beat.valid && sq_ready;

  // squared magnitudes against squared limits
  assign lin_sum  = CMP_W'(sq_beat.lin_sq_x) + CMP_W'(sq_beat.lin_sq_y) +
                    CMP_W'(sq_beat.lin_sq_z);
  assign ang_sum  = CMP_W'(sq_beat.ang_sq_x) + CMP_W'(sq_beat.ang_sq_y) +
                    CMP_W'(sq_beat.ang_sq_z);
  assign lin_over = lin_sum > CMP_W'(cfg.max_lin_sq);
  assign ang_over = ang_sum > CMP_W'(cfg.ang_sq);

  // first failing check decides the code
  always_comb begin
    code      = VIOL_SAFE;
    raised    = 1'b0;
    latch_nxt = stop_latch_r;
    if (sq_beat.command == CMD_RESET_STOP) begin
      latch_nxt = 1'b0;
    end else if (cfg.monitor_enable) begin
      if (lin_over) begin
        code = VIOL_LINEAR;
      end else if (cfg.axis_limit_mode != MODE_NONE) begin
        if (sq_beat.axis_over) begin
          code = VIOL_AXIS;
        end else if (cfg.axis_limit_mode != MODE_AXIS && ang_over) begin
          code = VIOL_ANGULAR;
        end
      end
      if (code != VIOL_SAFE && cfg.safety_level != LEVEL_LOW) begin
        raised    = 1'b1;
        latch_nxt = 1'b1;
      end
    end
  end

  // stop latch and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_latch_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        stop_latch_r <= latch_nxt;
      end
      if (sq_ready) begin
        out_valid_r <= sq_beat.valid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      viol_r   <= code;
      active_r <= latch_nxt;
      raised_r <= raised;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.violation   = viol_r;
  assign out_ch.stop_active = active_r;
  assign out_ch.stop_raised = raised_r;

endmodule
